[hw/rtl/cts_pkg.sv]
package cts_pkg;

  // Widths of the run length and the line counter, which saturate, and of the byte offset.
  localparam int LENGTH_BITS = 16;
  localparam int LINE_BITS   = 24;
  localparam int OFFSET_BITS = 32;

  // Result queue depth and pointer widths.
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // Token kinds.
  typedef enum logic [3:0] {
    KIND_END    = 4'd0,
    KIND_SEP    = 4'd1,
    KIND_NUMBER = 4'd2,
    KIND_IDENT  = 4'd3,
    KIND_ADD    = 4'd4,
    KIND_SUB    = 4'd5,
    KIND_MUL    = 4'd6,
    KIND_DIV    = 4'd7,
    KIND_REM    = 4'd8,
    KIND_POW    = 4'd9,
    KIND_ASSIGN = 4'd10,
    KIND_LPAREN = 4'd11,
    KIND_RPAREN = 4'd12,
    KIND_ERROR  = 4'd13
  } kind_t;

  // Error causes.
  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_INVALID  = 2'd1,
    CAUSE_OPEN_CMT = 2'd2
  } cause_t;

  // One result item as it sits in the queue.
  typedef struct packed {
    kind_t                   kind;
    cause_t                  cause;
    logic [LENGTH_BITS-1:0]  length;
    logic [OFFSET_BITS-1:0]  offset;
    logic [LINE_BITS-1:0]    line;
    logic                    last;
  } token_t;

endpackage

[hw/rtl/calculator_token_scanner.sv]
// Streaming lexer for calculator text. One text byte enters per cycle on the
// in channel and yields zero, one or two tokens, which leave one per cycle on
// the out channel; a zero byte closes the text and resets the line and offset
// counters. A byte is registered, decoded against the scan state in the next
// cycle, and its tokens are written into an eight-entry result queue whose
// head drives the out channel. The input stays open at one byte per cycle
// while the queue has room for two tokens beyond the byte in flight; since
// the out channel drains one token a cycle, text that averages more than one
// token per byte is paced by the out channel and its ready.
module calculator_token_scanner (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     ch,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [3:0]                     token_class,
  output logic [1:0]                     error_cause,
  output logic [cts_pkg::LENGTH_BITS-1:0] token_length,
  output logic [cts_pkg::OFFSET_BITS-1:0] token_offset,
  output logic [cts_pkg::LINE_BITS-1:0]  token_line,
  output logic                           last
);
  import cts_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_NUMBER = 3'd1,
    MODE_IDENT  = 3'd2,
    MODE_SLASH  = 3'd3,
    MODE_BLOCK  = 3'd4,
    MODE_HASH   = 3'd5
  } mode_t;

  // Decision for a byte that arrives between tokens.
  typedef struct packed {
    mode_t  mode;
    logic   emit;
    kind_t  kind;
    cause_t cause;
    logic   start;
    logic   run_one;
    logic   line_inc;
  } idle_t;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z], CH_UNDER};
  endfunction

  function automatic idle_t idle_eval(input logic [7:0] c);
    idle_t d;
    d = '{mode: MODE_IDLE, emit: 1'b1, kind: KIND_ERROR, cause: CAUSE_NONE,
          start: 1'b0, run_one: 1'b0, line_inc: 1'b0};
    case (c)
      CH_SPACE, CH_TAB, CH_CR: d.emit = 1'b0;
      CH_LF: begin
        d.kind     = KIND_SEP;
        d.line_inc = 1'b1;
      end
      CH_HASH: begin
        d.emit = 1'b0;
        d.mode = MODE_HASH;
      end
      CH_SLASH: begin
        d.emit  = 1'b0;
        d.mode  = MODE_SLASH;
        d.start = 1'b1;
      end
      CH_SEMI:   d.kind = KIND_SEP;
      CH_PLUS:   d.kind = KIND_ADD;
      CH_MINUS:  d.kind = KIND_SUB;
      CH_STAR:   d.kind = KIND_MUL;
      CH_PCT:    d.kind = KIND_REM;
      CH_CARET:  d.kind = KIND_POW;
      CH_EQUAL:  d.kind = KIND_ASSIGN;
      CH_LPAREN: d.kind = KIND_LPAREN;
      CH_RPAREN: d.kind = KIND_RPAREN;
      default: begin
        if (is_digit(c) || is_alpha(c)) begin
          d.emit    = 1'b0;
          d.mode    = is_digit(c) ? MODE_NUMBER : MODE_IDENT;
          d.start   = 1'b1;
          d.run_one = 1'b1;
        end else begin
          d.cause = CAUSE_INVALID;
        end
      end
    endcase
    return d;
  endfunction

  // Scan state.
  mode_t                  scan_mode, scan_mode_next;
  logic                   star_seen, star_seen_next;
  logic [LENGTH_BITS-1:0] run_length, run_length_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [LINE_BITS-1:0]   start_line, start_line_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0] start_offset, start_offset_next;

  // Input register.
  logic       s_valid;
  logic [7:0] s_ch;

  // Result queue.
  token_t            queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] q_count;

  // Decode results.
  token_t     res0, res1;
  logic [1:0] n_res;
  idle_t      idle_d;
  logic       cont;
  logic       pop;

  assign in_ready = ({1'b0, q_count} + (s_valid ? (QCNT_W + 1)'(2) : '0)) <=
                    (QCNT_W + 1)'(QUEUE_DEPTH - 2);
  assign pop       = out_valid && out_ready;
  assign out_valid = (q_count != '0);

  // Decode the registered byte against the scan state.
  always_comb begin
    scan_mode_next    = scan_mode;
    star_seen_next    = star_seen;
    run_length_next   = run_length;
    line_count_next   = line_count;
    start_line_next   = start_line;
    byte_offset_next  = byte_offset + OFFSET_BITS'(1);
    start_offset_next = start_offset;
    res0   = '0;
    res1   = '0;
    n_res  = 2'd0;
    idle_d = idle_eval(s_ch);
    cont   = is_digit(s_ch) || ((scan_mode == MODE_IDENT) && is_alpha(s_ch));

    if (s_ch == CH_NUL) begin
      // Flush a pending token, then close the text.
      if (scan_mode inside {MODE_NUMBER, MODE_IDENT}) begin
        res0 = '{kind: (scan_mode == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT,
                 cause: CAUSE_NONE, length: run_length, offset: start_offset,
                 line: start_line, last: 1'b0};
        n_res = 2'd1;
      end else if (scan_mode == MODE_SLASH) begin
        res0 = '{kind: KIND_DIV, cause: CAUSE_NONE, length: LENGTH_BITS'(1),
                 offset: start_offset, line: start_line, last: 1'b0};
        n_res = 2'd1;
      end
      if (n_res == 2'd1) begin
        res1 = '{kind: (scan_mode == MODE_BLOCK) ? KIND_ERROR : KIND_END,
                 cause: (scan_mode == MODE_BLOCK) ? CAUSE_OPEN_CMT : CAUSE_NONE,
                 length: '0, offset: byte_offset, line: line_count, last: 1'b0};
        n_res = 2'd2;
      end else begin
        res0 = '{kind: (scan_mode == MODE_BLOCK) ? KIND_ERROR : KIND_END,
                 cause: (scan_mode == MODE_BLOCK) ? CAUSE_OPEN_CMT : CAUSE_NONE,
                 length: '0, offset: byte_offset, line: line_count, last: 1'b0};
        n_res = 2'd1;
      end
      scan_mode_next    = MODE_IDLE;
      star_seen_next    = 1'b0;
      run_length_next   = '0;
      line_count_next   = LINE_ONE;
      start_line_next   = LINE_ONE;
      byte_offset_next  = '0;
      start_offset_next = '0;
    end else begin
      case (scan_mode)
        MODE_NUMBER, MODE_IDENT: begin
          if (cont) begin
            if (run_length < LEN_MAX) begin
              run_length_next = run_length + LENGTH_BITS'(1);
            end
          end else begin
            res0 = '{kind: (scan_mode == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT,
                     cause: CAUSE_NONE, length: run_length, offset: start_offset,
                     line: start_line, last: 1'b0};
            n_res = 2'd1;
            run_length_next = '0;
          end
        end
        MODE_SLASH: begin
          if (s_ch == CH_STAR) begin
            scan_mode_next = MODE_BLOCK;
            star_seen_next = 1'b0;
          end else begin
            res0 = '{kind: KIND_DIV, cause: CAUSE_NONE, length: LENGTH_BITS'(1),
                     offset: start_offset, line: start_line, last: 1'b0};
            n_res = 2'd1;
          end
        end
        MODE_BLOCK: begin
          if (star_seen && (s_ch == CH_SLASH)) begin
            scan_mode_next = MODE_IDLE;
            star_seen_next = 1'b0;
          end else begin
            star_seen_next = (s_ch == CH_STAR);
            if ((s_ch == CH_LF) && (line_count < LINE_MAX)) begin
              line_count_next = line_count + LINE_ONE;
            end
          end
        end
        default: ;
      endcase

      // The byte is handled as between tokens after a flush, after a lone
      // slash, on the newline that ends a hash comment, and in idle mode.
      if (((scan_mode inside {MODE_NUMBER, MODE_IDENT}) && !cont) ||
          ((scan_mode == MODE_SLASH) && (s_ch != CH_STAR)) ||
          ((scan_mode == MODE_HASH) && (s_ch == CH_LF)) ||
          !(scan_mode inside {MODE_NUMBER, MODE_IDENT, MODE_SLASH, MODE_BLOCK,
                              MODE_HASH})) begin
        scan_mode_next = idle_d.mode;
        if (idle_d.start) begin
          start_offset_next = byte_offset;
          start_line_next   = line_count;
        end
        if (idle_d.run_one) begin
          run_length_next = LENGTH_BITS'(1);
        end
        if (idle_d.line_inc && (line_count < LINE_MAX)) begin
          line_count_next = line_count + LINE_ONE;
        end
        if (idle_d.emit) begin
          if (n_res == 2'd0) begin
            res0 = '{kind: idle_d.kind, cause: idle_d.cause,
                     length: LENGTH_BITS'(1), offset: byte_offset,
                     line: line_count, last: 1'b0};
            n_res = 2'd1;
          end else begin
            res1 = '{kind: idle_d.kind, cause: idle_d.cause,
                     length: LENGTH_BITS'(1), offset: byte_offset,
                     line: line_count, last: 1'b0};
            n_res = 2'd2;
          end
        end
      end
    end

    // Mark the final token of this byte.
    res0.last = (n_res == 2'd1);
    res1.last = (n_res == 2'd2);
  end

  // Input register and scan state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid      <= 1'b0;
      scan_mode    <= MODE_IDLE;
      star_seen    <= 1'b0;
      run_length   <= '0;
      line_count   <= LINE_ONE;
      start_line   <= LINE_ONE;
      byte_offset  <= '0;
      start_offset <= '0;
    end else begin
      s_valid <= in_valid && in_ready;
      if (s_valid) begin
        scan_mode    <= scan_mode_next;
        star_seen    <= star_seen_next;
        run_length   <= run_length_next;
        line_count   <= line_count_next;
        start_line   <= start_line_next;
        byte_offset  <= byte_offset_next;
        start_offset <= start_offset_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_ch <= ch;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (s_valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      q_count <= q_count + (s_valid ? QCNT_W'(n_res) : '0) - (pop ? QCNT_W'(1) : '0);
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (s_valid && (n_res != 2'd0)) begin
      queue[wr_ptr] <= res0;
    end
    if (s_valid && (n_res == 2'd2)) begin
      queue[wr_ptr + QPTR_W'(1)] <= res1;
    end
  end

  // Head of the queue drives the out channel.
  assign token_class  = queue[rd_ptr].kind;
  assign error_cause  = queue[rd_ptr].cause;
  assign token_length = queue[rd_ptr].length;
  assign token_offset = queue[rd_ptr].offset;
  assign token_line   = queue[rd_ptr].line;
  assign last         = queue[rd_ptr].last;

  // The queue never overfills.
  assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // A zero byte restarts the text at offset zero, line one.
  assert property (@(posedge clk) disable iff (rst)
    (s_valid && (s_ch == CH_NUL)) |=> (byte_offset == '0) && (line_count == LINE_ONE))
    else $error("end of text did not reset the counters");

  // Every decoded byte that ends the text writes at least one token.
  assert property (@(posedge clk) disable iff (rst)
    (s_valid && (s_ch == CH_NUL)) |-> (n_res != 2'd0))
    else $error("end of text produced no token");

  // The line counter never reads zero.
  assert property (@(posedge clk) disable iff (rst)
    line_count != '0)
    else $error("line counter reached zero");

endmodule

[tb/calculator_token_scanner_test.sv]
`timescale 1ns / 1ps

module calculator_token_scanner_test;
  import cts_pkg::*;

  // Scanner modes of the predictor.
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_IDENT,
    SCAN_SLASH,
    SCAN_BLOCK,
    SCAN_HASH
  } scan_mode_t;

  // One row of the directed script; typed rows carry their own token.
  typedef struct {
    logic [7:0] b;
    bit         typed;
    token_t     tok;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             ch = 8'h00;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [3:0]             token_class;
  logic [1:0]             error_cause;
  logic [LENGTH_BITS-1:0] token_length;
  logic [OFFSET_BITS-1:0] token_offset;
  logic [LINE_BITS-1:0]   token_line;
  logic                   last;

  // Predictor state.
  scan_mode_t             mode = SCAN_IDLE;
  bit                     star_pending = 1'b0;
  logic [LENGTH_BITS-1:0] run_len = '0;
  logic [LINE_BITS-1:0]   line_no = 1;
  logic [LINE_BITS-1:0]   tok_line = 1;
  logic [OFFSET_BITS-1:0] offset = '0;
  logic [OFFSET_BITS-1:0] tok_off = '0;

  token_t      byte_tokens[$];
  token_t      pending_tokens[$];
  script_row_t script[$];
  int          failures = 0;
  int          text_bytes = 0;
  bit          steady = 1'b0;

  logic [7:0] op_chars[10] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT,
                               CH_CARET, CH_EQUAL, CH_LPAREN, CH_RPAREN, CH_SEMI};
  logic [7:0] blank_chars[3] = '{CH_SPACE, CH_TAB, CH_CR};

  calculator_token_scanner u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ch           (ch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_class  (token_class),
    .error_cause  (error_cause),
    .token_length (token_length),
    .token_offset (token_offset),
    .token_line   (token_line),
    .last         (last)
  );

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #40_000_000;
    $display("calculator_token_scanner verification failed");
    $finish;
  end

  function automatic bit is_digit(logic [7:0] b);
    return b inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic bit is_alpha(logic [7:0] b);
    return b inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z], CH_UNDER};
  endfunction

  function automatic logic [7:0] pick_alpha();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(CH_UPPER_A + r);
    if (r < 52) return 8'(CH_LOWER_A + (r - 26));
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] pick_alnum();
    if ($urandom_range(0, 62) < 53) return pick_alpha();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  task automatic emit_token(input kind_t k, input cause_t c, input logic [LENGTH_BITS-1:0] len,
                            input logic [OFFSET_BITS-1:0] off, input logic [LINE_BITS-1:0] ln);
    token_t t;
    t.kind   = k;
    t.cause  = c;
    t.length = len;
    t.offset = off;
    t.line   = ln;
    t.last   = 1'b0;
    byte_tokens.push_back(t);
  endtask

  task automatic bump_line();
    if (line_no != '1) line_no = line_no + 1'b1;
  endtask

  task automatic flush_run();
    emit_token(mode == SCAN_NUMBER ? KIND_NUMBER : KIND_IDENT, CAUSE_NONE, run_len, tok_off,
               tok_line);
    run_len = '0;
    mode = SCAN_IDLE;
  endtask

  task automatic clear_scan();
    mode = SCAN_IDLE;
    star_pending = 1'b0;
    run_len = '0;
    line_no = 1;
    tok_line = 1;
    offset = '0;
    tok_off = '0;
  endtask

  // A nonzero byte seen between tokens.
  task automatic scan_between(input logic [7:0] b);
    mode = SCAN_IDLE;
    case (b)
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_LF: begin
        emit_token(KIND_SEP, CAUSE_NONE, 1, offset, line_no);
        bump_line();
      end
      CH_HASH: mode = SCAN_HASH;
      CH_SLASH: begin
        mode = SCAN_SLASH;
        tok_off = offset;
        tok_line = line_no;
      end
      CH_SEMI:   emit_token(KIND_SEP, CAUSE_NONE, 1, offset, line_no);
      CH_PLUS:   emit_token(KIND_ADD, CAUSE_NONE, 1, offset, line_no);
      CH_MINUS:  emit_token(KIND_SUB, CAUSE_NONE, 1, offset, line_no);
      CH_STAR:   emit_token(KIND_MUL, CAUSE_NONE, 1, offset, line_no);
      CH_PCT:    emit_token(KIND_REM, CAUSE_NONE, 1, offset, line_no);
      CH_CARET:  emit_token(KIND_POW, CAUSE_NONE, 1, offset, line_no);
      CH_EQUAL:  emit_token(KIND_ASSIGN, CAUSE_NONE, 1, offset, line_no);
      CH_LPAREN: emit_token(KIND_LPAREN, CAUSE_NONE, 1, offset, line_no);
      CH_RPAREN: emit_token(KIND_RPAREN, CAUSE_NONE, 1, offset, line_no);
      default: begin
        if (is_digit(b) || is_alpha(b)) begin
          mode = is_digit(b) ? SCAN_NUMBER : SCAN_IDENT;
          run_len = 1;
          tok_off = offset;
          tok_line = line_no;
        end else begin
          emit_token(KIND_ERROR, CAUSE_INVALID, 1, offset, line_no);
        end
      end
    endcase
  endtask

  // Advance the predictor by one byte and leave its tokens in byte_tokens.
  task automatic scan_byte(input logic [7:0] b);
    byte_tokens.delete();
    if (b == CH_NUL) begin
      if (mode == SCAN_NUMBER || mode == SCAN_IDENT) begin
        flush_run();
      end else if (mode == SCAN_SLASH) begin
        emit_token(KIND_DIV, CAUSE_NONE, 1, tok_off, tok_line);
      end
      if (mode == SCAN_BLOCK) begin
        emit_token(KIND_ERROR, CAUSE_OPEN_CMT, 0, offset, line_no);
      end else begin
        emit_token(KIND_END, CAUSE_NONE, 0, offset, line_no);
      end
      clear_scan();
    end else begin
      case (mode)
        SCAN_NUMBER, SCAN_IDENT: begin
          if (is_digit(b) || (mode == SCAN_IDENT && is_alpha(b))) begin
            if (run_len != '1) run_len = run_len + 1'b1;
          end else begin
            flush_run();
            scan_between(b);
          end
        end
        SCAN_SLASH: begin
          if (b == CH_STAR) begin
            mode = SCAN_BLOCK;
            star_pending = 1'b0;
          end else begin
            emit_token(KIND_DIV, CAUSE_NONE, 1, tok_off, tok_line);
            scan_between(b);
          end
        end
        SCAN_BLOCK: begin
          if (star_pending && b == CH_SLASH) begin
            mode = SCAN_IDLE;
            star_pending = 1'b0;
          end else begin
            star_pending = (b == CH_STAR);
            if (b == CH_LF) bump_line();
          end
        end
        SCAN_HASH: begin
          if (b == CH_LF) scan_between(b);
        end
        default: scan_between(b);
      endcase
      offset = offset + 1'b1;
    end
    if (byte_tokens.size() != 0) byte_tokens[$].last = 1'b1;
  endtask

  // Offer one byte, wait for its handshake, and queue the tokens it causes.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input token_t typed_tok = '0);
    while (!steady && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= b;
    do @(negedge clk); while (!in_ready);
    scan_byte(b);
    if (typed) begin
      pending_tokens.push_back(typed_tok);
    end else begin
      foreach (byte_tokens[i]) pending_tokens.push_back(byte_tokens[i]);
    end
    text_bytes++;
    @(posedge clk);
  endtask

  // Stop offering bytes until every queued token has come out.
  task automatic drain_tokens();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
  endtask

  task automatic add_row(input logic [7:0] b);
    script_row_t r;
    r.b = b;
    r.typed = 1'b0;
    r.tok = '0;
    script.push_back(r);
  endtask

  task automatic add_typed(input logic [7:0] b, input kind_t k, input cause_t c,
                           input int len, input int off, input int ln);
    script_row_t r;
    r.b = b;
    r.typed = 1'b1;
    r.tok.kind = k;
    r.tok.cause = c;
    r.tok.length = LENGTH_BITS'(len);
    r.tok.offset = OFFSET_BITS'(off);
    r.tok.line = LINE_BITS'(ln);
    r.tok.last = 1'b1;
    script.push_back(r);
  endtask

  // One well-formed piece of text with random content, or a piece of noise.
  task automatic send_fragment();
    int pick;
    int n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 24) begin
      n = $urandom_range(1, 5);
      repeat (n) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    end else if (pick < 44) begin
      send_byte(pick_alpha());
      n = $urandom_range(0, 6);
      repeat (n) send_byte(pick_alnum());
    end else if (pick < 64) begin
      send_byte(op_chars[$urandom_range(0, 9)]);
    end else if (pick < 73) begin
      send_byte(blank_chars[$urandom_range(0, 2)]);
    end else if (pick < 78) begin
      send_byte(CH_LF);
    end else if (pick < 83) begin
      // Hash comment, usually closed by a newline.
      send_byte(CH_HASH);
      n = $urandom_range(0, 8);
      repeat (n) begin
        b = 8'($urandom_range(1, 255));
        send_byte(b == CH_LF ? CH_HASH : b);
      end
      if ($urandom_range(99) < 80) send_byte(CH_LF);
    end else if (pick < 91) begin
      // Block comment with stars, slashes and newlines inside.
      send_byte(CH_SLASH);
      send_byte(CH_STAR);
      n = $urandom_range(0, 10);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: send_byte(CH_STAR);
          1: send_byte(CH_SLASH);
          2: send_byte(CH_LF);
          default: send_byte(8'($urandom_range(1, 255)));
        endcase
      end
      if ($urandom_range(99) < 85) begin
        send_byte(CH_STAR);
        send_byte(CH_SLASH);
      end
    end else if (pick < 97) begin
      send_byte(8'($urandom_range(1, 255)));
    end else begin
      send_byte(CH_NUL);
    end
  endtask

  // Stimulus.
  initial begin
    int start_count;
    bit paused;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed script: extremes, every operator, comments and both endings.
    add_typed(CH_NUL, KIND_END, CAUSE_NONE, 0, 0, 1);
    add_typed(8'hFF, KIND_ERROR, CAUSE_INVALID, 1, 0, 1);
    add_typed(8'h80, KIND_ERROR, CAUSE_INVALID, 1, 1, 1);
    add_typed(CH_LPAREN, KIND_LPAREN, CAUSE_NONE, 1, 2, 1);
    add_row(CH_NINE);
    add_row(CH_ZERO);
    add_row(CH_PLUS);
    add_row(CH_MINUS);
    add_row(CH_STAR);
    add_row(CH_PCT);
    add_row(CH_CARET);
    add_row(CH_EQUAL);
    add_row(CH_RPAREN);
    add_row(CH_SEMI);
    add_row(CH_SPACE);
    add_row(CH_TAB);
    add_row(CH_CR);
    add_row(CH_UNDER);
    add_row(CH_LOWER_Z);
    add_row(CH_UPPER_A);
    // Slash-star-slash must not close the comment.
    add_row(CH_SLASH);
    add_row(CH_STAR);
    add_row(CH_SLASH);
    add_row(CH_LF);
    add_row(CH_STAR);
    add_row(CH_SLASH);
    add_row(CH_HASH);
    add_row(CH_LOWER_A);
    add_row(CH_LF);
    // A lone slash is flushed ahead of the end token.
    add_row(CH_SLASH);
    add_row(CH_NUL);
    // Text that ends inside a block comment.
    add_row(CH_SLASH);
    add_row(CH_STAR);
    add_typed(CH_NUL, KIND_ERROR, CAUSE_OPEN_CMT, 0, 2, 1);
    foreach (script[i]) send_byte(script[i].b, script[i].typed, script[i].tok);

    // Random text, with a stretch free of idling and one full drain.
    start_count = text_bytes;
    paused = 1'b0;
    while (text_bytes - start_count < 1800) begin
      steady = (text_bytes - start_count >= 400) && (text_bytes - start_count < 750);
      if (!paused && text_bytes - start_count >= 1000) begin
        drain_tokens();
        paused = 1'b1;
      end
      send_fragment();
    end
    steady = 1'b0;
    send_byte(CH_NUL);

    // Wait for the last tokens, then a few more cycles for strays.
    drain_tokens();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("calculator_token_scanner verification clean");
    end else begin
      $display("calculator_token_scanner verification failed");
    end
    $finish;
  end

  // Receiver readiness.
  always @(posedge clk) begin
    out_ready <= !rst && (steady || $urandom_range(99) >= 25);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // Compare each token that will be taken at the coming edge.
  always @(negedge clk) begin
    token_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual kind %0d offset %0d",
                 $time, token_class, token_offset);
        failures++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_class", 32'(want.kind), 32'(token_class));
        check_field("error_cause", 32'(want.cause), 32'(error_cause));
        check_field("token_length", 32'(want.length), 32'(token_length));
        check_field("token_offset", want.offset, token_offset);
        check_field("token_line", 32'(want.line), 32'(token_line));
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

endmodule

[sim.f]
hw/rtl/cts_pkg.sv
hw/rtl/calculator_token_scanner.sv
tb/calculator_token_scanner_test.sv
